[hdl/frd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_pkg: shared definitions for the fraction reducer
// Word width, controller states, datapath operations, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package frd_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(WORD_WIDTH);

   typedef logic signed [WORD_WIDTH-1:0] frd_word_type;
   typedef logic        [WORD_WIDTH-1:0] frd_mag_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TWOS,
      ST_REDUCE,
      ST_DIVIDE,
      ST_STORE
   } frd_state_type;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_TWOS,
      OP_REDUCE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_STORE
   } frd_op_type;

   typedef struct packed {
      frd_op_type op;
   } frd_cmd_type;

   typedef struct packed {
      logic special;    // zero numerator or zero denominator
      logic twos_done;  // at least one operand is odd
      logic gcd_done;   // both operands equal: odd part of the gcd found
      logic div_last;   // this division step is the final one
      logic out_free;   // result register can take a new result
   } frd_status_type;

endpackage
`default_nettype wire

[hdl/frd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_if: valid/ready channels of the fraction reducer
// One interface carries the input fraction, the other the reduced result.
// ----------------------------------------------------------------------------
interface frd_req_if import frd_pkg::*; ();
   logic         valid;
   logic         ready;
   frd_word_type numerator;
   frd_word_type denominator;

   modport source (output valid, output numerator, output denominator, input ready);
   modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frd_rsp_if import frd_pkg::*; ();
   logic         valid;
   logic         ready;
   frd_word_type reduced_numerator;
   frd_word_type reduced_denominator;
   logic         zero_denominator;

   modport source (output valid, output reduced_numerator, output reduced_denominator,
                   output zero_denominator, input ready);
   modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                   input zero_denominator, output ready);
endinterface
`default_nettype wire

[hdl/frd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_ctrl: sequencing state machine
// Steps the datapath through factor-of-two removal, binary GCD reduction,
// the division of both magnitudes by the shared gcd and the final result store.
// ----------------------------------------------------------------------------
module frd_ctrl import frd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire frd_status_type status,
   output frd_cmd_type         cmd
);

   frd_state_type state_ff;
   frd_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_TWOS;
            end
         end
         ST_TWOS: begin
            // Special cases need no arithmetic at all.
            if (status.special) begin
               state_in = ST_STORE;
            end else if (status.twos_done) begin
               state_in = ST_REDUCE;
            end else begin
               cmd.op = OP_TWOS;
            end
         end
         ST_REDUCE: begin
            if (status.gcd_done) begin
               cmd.op   = OP_DIV_INIT;
               state_in = ST_DIVIDE;
            end else begin
               cmd.op = OP_REDUCE;
            end
         end
         ST_DIVIDE: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            // Wait until the result register is free.
            if (status.out_free) begin
               cmd.op   = OP_STORE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[hdl/frd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frd_dp: fraction reducer datapath
// Binary GCD of the two magnitudes, then two restoring dividers that share
// the gcd as divisor, then sign restore into the result register.
// ----------------------------------------------------------------------------
module frd_dp import frd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire frd_cmd_type  cmd,
   output frd_status_type    status,
   input  wire frd_word_type req_numerator,
   input  wire frd_word_type req_denominator,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output frd_word_type      rsp_reduced_numerator,
   output frd_word_type      rsp_reduced_denominator,
   output logic              rsp_zero_denominator
);

   // Two's complement magnitude; the most negative value maps to 2^(W-1).
   function automatic frd_mag_type mag_of(input frd_word_type v);
      frd_mag_type r;
      r = frd_mag_type'(v);
      if (v[WORD_WIDTH-1]) begin
         r = frd_mag_type'(~r + 1'b1);
      end
      return r;
   endfunction

   function automatic frd_word_type sign_of(input frd_mag_type m, input logic neg);
      frd_word_type r;
      r = frd_word_type'(m);
      if (neg) begin
         r = -r;
      end
      return r;
   endfunction

   frd_word_type         num_ff, num_in;
   frd_word_type         den_ff, den_in;
   frd_mag_type          a_ff, a_in;
   frd_mag_type          b_ff, b_in;
   logic [CNT_WIDTH-1:0] k_ff, k_in;
   frd_mag_type          g_ff, g_in;
   frd_mag_type          nq_ff, nq_in;
   frd_mag_type          dq_ff, dq_in;
   frd_mag_type          nr_ff, nr_in;
   frd_mag_type          dr_ff, dr_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   frd_word_type         out_num_ff, out_num_in;
   frd_word_type         out_den_ff, out_den_in;
   logic                 out_zd_ff, out_zd_in;

   frd_mag_type nsh;
   frd_mag_type dsh;

   // Status back to the controller.
   always_comb begin
      status.special   = (num_ff == '0) || (den_ff == '0);
      status.twos_done = a_ff[0] || b_ff[0];
      status.gcd_done  = (a_ff == b_ff);
      status.div_last  = (cnt_ff == CNT_WIDTH'(WORD_WIDTH - 1));
      status.out_free  = !out_valid_ff || rsp_ready;
   end

   // Partial remainders of both restoring dividers; remainders stay below
   // the gcd, which is at most 2^(W-1), so the top bit is always clear.
   assign nsh = {nr_ff[WORD_WIDTH-2:0], nq_ff[WORD_WIDTH-1]};
   assign dsh = {dr_ff[WORD_WIDTH-2:0], dq_ff[WORD_WIDTH-1]};

   // Working register updates.
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      k_in   = k_ff;
      g_in   = g_ff;
      nq_in  = nq_ff;
      dq_in  = dq_ff;
      nr_in  = nr_ff;
      dr_in  = dr_ff;
      cnt_in = cnt_ff;
      case (cmd.op)
         OP_LOAD: begin
            num_in = req_numerator;
            den_in = req_denominator;
            a_in   = mag_of(req_numerator);
            b_in   = mag_of(req_denominator);
            k_in   = '0;
         end
         OP_TWOS: begin
            // Common factors of two are counted and put back later.
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end
         OP_REDUCE: begin
            if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff > b_ff) begin
               a_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end
         OP_DIV_INIT: begin
            g_in   = a_ff << k_ff;
            nq_in  = mag_of(num_ff);
            dq_in  = mag_of(den_ff);
            nr_in  = '0;
            dr_in  = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            // One quotient bit per lane; the quotient shifts in from the right.
            if (nsh >= g_ff) begin
               nr_in = nsh - g_ff;
               nq_in = {nq_ff[WORD_WIDTH-2:0], 1'b1};
            end else begin
               nr_in = nsh;
               nq_in = {nq_ff[WORD_WIDTH-2:0], 1'b0};
            end
            if (dsh >= g_ff) begin
               dr_in = dsh - g_ff;
               dq_in = {dq_ff[WORD_WIDTH-2:0], 1'b1};
            end else begin
               dr_in = dsh;
               dq_in = {dq_ff[WORD_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Result register: filled on store, emptied by a result transfer.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_zd_in    = out_zd_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.op == OP_STORE) begin
         out_valid_in = 1'b1;
         if (den_ff == '0) begin
            out_num_in = num_ff;
            out_den_in = '0;
            out_zd_in  = 1'b1;
         end else if (num_ff == '0) begin
            out_num_in = '0;
            out_den_in = frd_word_type'(1);
            out_zd_in  = 1'b0;
         end else begin
            out_num_in = sign_of(nq_ff, num_ff[WORD_WIDTH-1]);
            out_den_in = sign_of(dq_ff, den_ff[WORD_WIDTH-1]);
            out_zd_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      den_ff     <= den_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      nq_ff      <= nq_in;
      dq_ff      <= dq_in;
      nr_ff      <= nr_in;
      dr_ff      <= dr_in;
      cnt_ff     <= cnt_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_zd_ff  <= out_zd_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_reduced_numerator   = out_num_ff;
   assign rsp_reduced_denominator = out_den_ff;
   assign rsp_zero_denominator    = out_zd_ff;

endmodule
`default_nettype wire

[hdl/fraction_reducer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_reducer: signed fraction to lowest terms
// Divides numerator and denominator by the gcd of their magnitudes, each
// keeping its own sign. Zero numerator gives 0/1; zero denominator passes
// the pair through and raises zero_denominator.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// req_ch    in         numerator, denominator
// rsp_ch    out        reduced_numerator, reduced_denominator, zero_denominator
//
// One item at a time. A special case goes from the load straight through
// the factor-of-two state to the store. Otherwise the steps are: load,
// one shift per common factor of two, a pass that leaves that loop, binary
// GCD steps (one subtract or shift each), divider setup, WORD_WIDTH restoring
// division steps and the store. The two loops set the variable part.
// The result register frees the controller to take the next item while a
// result waits; a stalled result holds the next store. Reset is synchronous
// and clears only the controller and the result valid.
// ----------------------------------------------------------------------------
module fraction_reducer import frd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   frd_req_if.sink   req_ch,
   frd_rsp_if.source rsp_ch
);

   frd_cmd_type    cmd;
   frd_status_type status;

   frd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   frd_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_numerator           (req_ch.numerator),
      .req_denominator         (req_ch.denominator),
      .rsp_valid               (rsp_ch.valid),
      .rsp_ready               (rsp_ch.ready),
      .rsp_reduced_numerator   (rsp_ch.reduced_numerator),
      .rsp_reduced_denominator (rsp_ch.reduced_denominator),
      .rsp_zero_denominator    (rsp_ch.zero_denominator)
   );

   // An input transfer always loads the datapath.
   a_load_on_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (cmd.op == OP_LOAD))
      else $error("input transfer without datapath load");

   // A store always leaves a valid result.
   a_store_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_STORE) |=> rsp_ch.valid)
      else $error("store did not produce a valid result");

   // The zero denominator flag goes with a zero denominator only.
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.zero_denominator == (rsp_ch.reduced_denominator == '0)))
      else $error("zero denominator flag disagrees with result");

   // A store never overwrites a result that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_STORE) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result overwritten before transfer");

endmodule
`default_nettype wire
